// ----- src/rbd_pkg.sv -----
package rbd_pkg;

	// word and field widths
	localparam int DATA_W = 32;
	localparam int CNT_W  = 5;
	localparam int REQ_W  = 3;
	localparam int ST_W   = 2;

	// capacity after reset
	localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// result of one request, minus the word read from the store
	typedef struct packed {
		logic             rd;
		logic [ST_W-1:0]  status;
		logic [CNT_W-1:0] count;
		logic             empty;
		logic             full;
	} res_info_t;

endpackage

// ----- src/rbd_ram.sv -----
module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- src/rbd_ctrl.sv -----
module rbd_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [rbd_pkg::CNT_W-1:0]         capacity_in_use,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rbd_pkg::REQ_W-1:0]         req_type,
	input  logic signed [rbd_pkg::DATA_W-1:0] push_value,
	input  logic                              s2_free,
	output logic                              valid_s1,
	output rbd_pkg::res_info_t                info_s1,
	output logic                              ram_we,
	output logic                              ram_re,
	output logic [$clog2(DEPTH)-1:0]          ram_addr,
	output logic [rbd_pkg::DATA_W-1:0]        ram_wdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = rbd_pkg::CNT_W;
	localparam int WW    = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
	localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
	localparam logic [CNT_W-1:0] CAP_RST =
		(DEPTH < int'(rbd_pkg::CAP_RESET)) ? CNT_W'(DEPTH) : rbd_pkg::CAP_RESET;

	logic [CNT_W-1:0] cap_q;
	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	logic [CNT_W-1:0] cap_clamp;
	logic [WW-1:0]    cap_w;
	logic [WW-1:0]    front_w;
	logic [WW-1:0]    count_w;
	logic             full_now;
	logic             empty_now;
	logic [PTR_W-1:0] front_nxt;
	logic [CNT_W-1:0] count_nxt;
	logic [PTR_W-1:0] addr;
	logic             wr;
	logic             rd;
	logic [rbd_pkg::ST_W-1:0] st;
	logic             accept;

	// (a + b) mod cap, for a sum below twice cap
	function automatic logic [WW-1:0] wrap(input logic [WW-1:0] s, input logic [WW-1:0] cap);
		logic [WW-1:0] r;
		r = (s >= cap) ? s - cap : s;
		return r;
	endfunction

	// stall while the first stage holds a word the output cannot take
	assign in_stall = valid_s1 & ~s2_free;
	assign accept   = in_valid & ~in_stall;

	// limit a written capacity to 1..DEPTH
	always_comb begin
		if (capacity_in_use == '0) begin
			cap_clamp = CNT_W'(1);
		end else if (WW'(capacity_in_use) > DEPTH_W) begin
			cap_clamp = CNT_W'(DEPTH);
		end else begin
			cap_clamp = capacity_in_use;
		end
	end

	assign cap_w     = WW'(cap_q);
	assign front_w   = WW'(front_q);
	assign count_w   = WW'(count_q);
	assign full_now  = (count_q == cap_q);
	assign empty_now = (count_q == '0);

	// decode the request: next pointer and count, store access, status
	always_comb begin
		front_nxt = front_q;
		count_nxt = count_q;
		addr      = front_q;
		wr        = 1'b0;
		rd        = 1'b0;
		st        = rbd_pkg::ST_OK;
		case (req_type) inside
			rbd_pkg::REQ_PUSH_FRONT: begin
				if (full_now) begin
					st = rbd_pkg::ST_FULL;
				end else begin
					if (front_q == '0) begin
						front_nxt = PTR_W'(cap_w - WW'(1));
					end else begin
						front_nxt = front_q - PTR_W'(1);
					end
					addr      = front_nxt;
					wr        = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			rbd_pkg::REQ_PUSH_BACK: begin
				if (full_now) begin
					st = rbd_pkg::ST_FULL;
				end else begin
					addr      = PTR_W'(wrap(front_w + count_w, cap_w));
					wr        = 1'b1;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_PEEK_FRONT: begin
				if (empty_now) begin
					st = rbd_pkg::ST_EMPTY;
				end else begin
					rd   = 1'b1;
					addr = front_q;
					if (req_type == rbd_pkg::REQ_POP_FRONT) begin
						front_nxt = PTR_W'(wrap(front_w + WW'(1), cap_w));
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			rbd_pkg::REQ_POP_BACK, rbd_pkg::REQ_PEEK_BACK: begin
				if (empty_now) begin
					st = rbd_pkg::ST_EMPTY;
				end else begin
					rd   = 1'b1;
					addr = PTR_W'(wrap(front_w + count_w - WW'(1), cap_w));
					if (req_type == rbd_pkg::REQ_POP_BACK) begin
						count_nxt = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = accept & wr;
	assign ram_re    = accept & rd;
	assign ram_addr  = addr;
	assign ram_wdata = $unsigned(push_value);

	// capacity, front pointer and count; a capacity write empties the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RST;
			front_q <= '0;
			count_q <= '0;
		end else if (cfg_write) begin
			cap_q   <= cap_clamp;
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// first stage valid: fill on accept, drain when the output takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s2_free) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold the result info while the store read is in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1.rd     <= rd;
			info_s1.status <= st;
			info_s1.count  <= count_nxt;
			info_s1.empty  <= (count_nxt == '0);
			info_s1.full   <= (count_nxt == cap_q);
		end
	end

	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("word count above capacity");

	a_front_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		front_w < cap_w)
		else $error("front pointer outside the ring");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !cfg_write && !full_now &&
		(req_type == rbd_pkg::REQ_PUSH_FRONT || req_type == rbd_pkg::REQ_PUSH_BACK)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the count");

endmodule

// ----- src/ring_buffer_deque.sv -----
// After its request word is accepted, a result passes the registered read of the
// slot store and then the output register.
// Throughput: one request per cycle unless in_stall is high; the slot store
// has one port and each request reads or writes it at most once.
// Reset (arst_n low): queue empty, front pointer zero, capacity 16 (or DEPTH if
// smaller), both stages empty; slot contents are left as they are.
module ring_buffer_deque #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [rbd_pkg::CNT_W-1:0]         capacity_in_use,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rbd_pkg::REQ_W-1:0]         req_type,
	input  logic signed [rbd_pkg::DATA_W-1:0] push_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rbd_pkg::DATA_W-1:0] read_value,
	output logic [rbd_pkg::ST_W-1:0]          status,
	output logic [rbd_pkg::CNT_W-1:0]         entry_count,
	output logic                              is_empty,
	output logic                              is_full
);

	logic                       s2_free;
	logic                       valid_s1;
	rbd_pkg::res_info_t         info_s1;
	logic                       ram_we;
	logic                       ram_re;
	logic [$clog2(DEPTH)-1:0]   ram_addr;
	logic [rbd_pkg::DATA_W-1:0] ram_wdata;
	logic [rbd_pkg::DATA_W-1:0] ram_rdata;

	logic                              valid_s2;
	logic signed [rbd_pkg::DATA_W-1:0] read_value_s2;
	logic [rbd_pkg::ST_W-1:0]          status_s2;
	logic [rbd_pkg::CNT_W-1:0]         count_s2;
	logic                              empty_s2;
	logic                              full_s2;

	rbd_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.capacity_in_use(capacity_in_use),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.push_value     (push_value),
		.s2_free        (s2_free),
		.valid_s1       (valid_s1),
		.info_s1        (info_s1),
		.ram_we         (ram_we),
		.ram_re         (ram_re),
		.ram_addr       (ram_addr),
		.ram_wdata      (ram_wdata)
	);

	rbd_ram #(
		.WIDTH(rbd_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// output register takes a new word when empty or when its word leaves
	assign s2_free = ~valid_s2 | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// load the result; the read word only for a pop or peek that succeeded
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			read_value_s2 <= info_s1.rd ? $signed(ram_rdata) : '0;
			status_s2     <= info_s1.status;
			count_s2      <= info_s1.count;
			empty_s2      <= info_s1.empty;
			full_s2       <= info_s1.full;
		end
	end

	assign out_valid   = valid_s2;
	assign read_value  = read_value_s2;
	assign status      = status_s2;
	assign entry_count = count_s2;
	assign is_empty    = empty_s2;
	assign is_full     = full_s2;

endmodule
